// ===== rtl/gffrc_pkg.sv =====
// Shared constants, codes and types for the grid flood-fill reach checker.
`timescale 1ns / 1ps
`default_nettype none

package gffrc_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int LOAD_W    = ADDR_W + 1;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int STACK_W   = ROW_W + COL_W;
    localparam int DIM_W     = 7;
    localparam int CNT_W     = 13;
    localparam int KIND_W    = 3;
    localparam int REG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_FLOOR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COLLECT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EXIT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PLAYER  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_VISITED = 3'd7;

    localparam logic [REG_IDX_W-1:0] REG_ROWS        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLS        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TOT_COLLECT = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TOT_EXITS   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TOT_PLAYERS = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] cell_kind;
        logic              last_cell;
    } gffrc_item_t;

    typedef struct packed {
        logic             path_valid;
        logic [CNT_W-1:0] reached_collectibles;
        logic [CNT_W-1:0] reached_exits;
        logic [CNT_W-1:0] reached_players;
    } gffrc_result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_SEED,
        OP_ADDR,
        OP_READ,
        OP_MARK,
        OP_POP,
        OP_TAKE,
        OP_NBR,
        OP_FINISH
    } gffrc_op_t;

    typedef enum logic [1:0] {
        NBR_LEFT,
        NBR_RIGHT,
        NBR_UP,
        NBR_DOWN
    } gffrc_nbr_t;

    typedef struct packed {
        gffrc_op_t  op;
        gffrc_nbr_t nbr;
    } gffrc_cmd_t;

    typedef struct packed {
        logic div_done;
        logic idx_ok;
        logic sp_zero;
    } gffrc_status_t;

endpackage

`default_nettype wire

// ===== rtl/gffrc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module gffrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/gffrc_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gffrc_div import gffrc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ADDR_W-1:0] dividend,
    input  logic [DIM_W-1:0]  divisor,
    output logic              done,
    output logic [ADDR_W-1:0] quotient,
    output logic [DIM_W-1:0]  remainder
);

    localparam int STEP_W = $clog2(ADDR_W + 1);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ADDR_W-1:0] quo_reg, quo_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W:0]    trial;
    logic [DIM_W:0]    diff;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[ADDR_W-1]};
        diff      = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            run_next  = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (run_reg)
        begin
            quo_next  = {quo_reg[ADDR_W-2:0], fits};
            rem_next  = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ADDR_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/gffrc_ctrl.sv =====
// Sequencer for loading, start-position recovery and the stack-driven fill.
`timescale 1ns / 1ps
`default_nettype none

module gffrc_ctrl import gffrc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          last_cell,
    input  gffrc_status_t status,
    output gffrc_cmd_t    cmd,
    output logic          busy,
    output logic          done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SEED,
        S_ADDR,
        S_READ,
        S_MARK,
        S_POP,
        S_TAKE,
        S_NBR,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    gffrc_nbr_t nbr_reg, nbr_next;
    logic       seed_reg, seed_next;
    state_t     after_visit;

    // After a visit: the seed and the last (down) neighbour go to the stack pop, others move on
    always_comb
    begin
        after_visit = (seed_reg || nbr_reg == NBR_DOWN) ? S_POP : S_NBR;
    end

    always_comb
    begin
        state_next = state_reg;
        nbr_next   = nbr_reg;
        seed_next  = seed_reg;
        cmd.op     = OP_NONE;
        cmd.nbr    = nbr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    if (last_cell)
                    begin
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_DIV_GO:
            begin
                cmd.op     = OP_DIV;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                cmd.op     = OP_SEED;
                seed_next  = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.op     = OP_ADDR;
                state_next = S_READ;
            end
            S_READ:
            begin
                if (status.idx_ok)
                begin
                    cmd.op     = OP_READ;
                    state_next = S_MARK;
                end
                else
                begin
                    state_next = after_visit;
                    if (!seed_reg)
                    begin
                        nbr_next = gffrc_nbr_t'(nbr_reg + 2'd1);
                    end
                end
            end
            S_MARK:
            begin
                cmd.op     = OP_MARK;
                state_next = after_visit;
                if (!seed_reg)
                begin
                    nbr_next = gffrc_nbr_t'(nbr_reg + 2'd1);
                end
            end
            S_POP:
            begin
                if (status.sp_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    state_next = S_TAKE;
                end
            end
            S_TAKE:
            begin
                cmd.op     = OP_TAKE;
                seed_next  = 1'b0;
                nbr_next   = NBR_LEFT;
                state_next = S_NBR;
            end
            S_NBR:
            begin
                cmd.op     = OP_NBR;
                state_next = S_ADDR;
            end
            S_DONE:
            begin
                cmd.op     = OP_FINISH;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nbr_reg   <= NBR_LEFT;
            seed_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            nbr_reg   <= nbr_next;
            seed_reg  <= seed_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ===== rtl/gffrc_dp.sv =====
// Datapath: settings, counters, grid and stack memories, address arithmetic.
`timescale 1ns / 1ps
`default_nettype none

module gffrc_dp import gffrc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gffrc_cmd_t           cmd,
    output gffrc_status_t        status,
    input  logic [KIND_W-1:0]    cell_kind,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    output gffrc_result_t        result
);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

    logic [DIM_W-1:0]  rows_reg, rows_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;
    logic [CNT_W-1:0]  tot_c_reg, tot_c_next;
    logic [CNT_W-1:0]  tot_e_reg, tot_e_next;
    logic [CNT_W-1:0]  tot_p_reg, tot_p_next;
    logic [LOAD_W-1:0] load_idx_reg, load_idx_next;
    logic [ADDR_W-1:0] start_idx_reg, start_idx_next;
    logic [DIM_W-1:0]  start_nc_reg, start_nc_next;
    logic [CNT_W-1:0]  cnt_c_reg, cnt_c_next;
    logic [CNT_W-1:0]  cnt_e_reg, cnt_e_next;
    logic [CNT_W-1:0]  cnt_p_reg, cnt_p_next;
    logic [LOAD_W-1:0] sp_reg, sp_next;
    logic              cand_ok_reg, cand_ok_next;
    logic              idx_ok_reg, idx_ok_next;
    logic [ADDR_W-1:0] cand_r_reg, cand_r_next;
    logic [DIM_W-1:0]  cand_c_reg, cand_c_next;
    logic [ROW_W-1:0]  cur_r_reg, cur_r_next;
    logic [COL_W-1:0]  cur_c_reg, cur_c_next;
    logic [LOAD_W-1:0] idx_reg, idx_next;

    logic [DIM_W-1:0]        nr;
    logic [DIM_W-1:0]        nc;
    logic [2*DIM_W-1:0]      area;
    logic                    store_ok;
    logic [ROW_W+DIM_W-1:0]  prod;
    logic [LOAD_W-1:0]       sp_dec;
    logic                    open_kind;

    logic                    grid_we;
    logic [ADDR_W-1:0]       grid_waddr;
    logic [KIND_W-1:0]       grid_wdata;
    logic [KIND_W-1:0]       grid_rdata;
    logic                    stack_we;
    logic [STACK_W-1:0]      stack_rdata;

    logic                    div_done;
    logic [ADDR_W-1:0]       div_quo;
    logic [DIM_W-1:0]        div_rem;

    assign nr       = (rows_reg > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_reg;
    assign nc       = (cols_reg > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_reg;
    assign area     = nr * nc;
    assign store_ok = ((2*DIM_W)'(load_idx_reg) < area);
    assign prod     = cand_r_reg[ROW_W-1:0] * nc;
    assign sp_dec   = sp_reg - LOAD_W'(1);
    assign open_kind = (grid_rdata >= KIND_FLOOR) && (grid_rdata <= KIND_PLAYER);

    always_comb
    begin
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        tot_c_next     = tot_c_reg;
        tot_e_next     = tot_e_reg;
        tot_p_next     = tot_p_reg;
        load_idx_next  = load_idx_reg;
        start_idx_next = start_idx_reg;
        start_nc_next  = start_nc_reg;
        cnt_c_next     = cnt_c_reg;
        cnt_e_next     = cnt_e_reg;
        cnt_p_next     = cnt_p_reg;
        sp_next        = sp_reg;
        cand_ok_next   = cand_ok_reg;
        idx_ok_next    = idx_ok_reg;
        cand_r_next    = cand_r_reg;
        cand_c_next    = cand_c_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        idx_next       = idx_reg;
        grid_we        = 1'b0;
        grid_waddr     = idx_reg[ADDR_W-1:0];
        grid_wdata     = KIND_VISITED;
        stack_we       = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS:        rows_next  = cfg_data[DIM_W-1:0];
                REG_COLS:        cols_next  = cfg_data[DIM_W-1:0];
                REG_TOT_COLLECT: tot_c_next = cfg_data;
                REG_TOT_EXITS:   tot_e_next = cfg_data;
                REG_TOT_PLAYERS: tot_p_next = cfg_data;
                default:         ;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                if (load_idx_reg == '0)
                begin
                    cnt_c_next     = '0;
                    cnt_e_next     = '0;
                    cnt_p_next     = '0;
                    start_idx_next = '0;
                end
                if (store_ok)
                begin
                    grid_we       = 1'b1;
                    grid_waddr    = load_idx_reg[ADDR_W-1:0];
                    grid_wdata    = cell_kind;
                    load_idx_next = load_idx_reg + LOAD_W'(1);
                    // Keep the linear position and stride; split it once the load ends
                    if (cell_kind == KIND_PLAYER)
                    begin
                        start_idx_next = load_idx_reg[ADDR_W-1:0];
                        start_nc_next  = nc;
                    end
                end
            end
            OP_SEED:
            begin
                sp_next      = '0;
                cand_r_next  = div_quo;
                cand_c_next  = div_rem;
            end
            OP_NBR:
            begin
                // Stepping off the low edge wraps to all ones and fails the bound check
                cand_r_next = ADDR_W'(cur_r_reg);
                cand_c_next = DIM_W'(cur_c_reg);
                case (cmd.nbr)
                    NBR_LEFT:  cand_c_next = DIM_W'(cur_c_reg) - DIM_W'(1);
                    NBR_RIGHT: cand_c_next = DIM_W'(cur_c_reg) + DIM_W'(1);
                    NBR_UP:    cand_r_next = ADDR_W'(cur_r_reg) - ADDR_W'(1);
                    NBR_DOWN:  cand_r_next = ADDR_W'(cur_r_reg) + ADDR_W'(1);
                    default:   ;
                endcase
            end
            OP_ADDR:
            begin
                idx_next    = LOAD_W'(prod) + LOAD_W'(cand_c_reg[COL_W-1:0]);
                idx_ok_next = cand_ok_reg && (idx_next < load_idx_reg);
            end
            OP_MARK:
            begin
                if (open_kind)
                begin
                    if (grid_rdata == KIND_COLLECT)
                    begin
                        cnt_c_next = sat_inc(cnt_c_reg);
                    end
                    if (grid_rdata == KIND_EXIT)
                    begin
                        cnt_e_next = sat_inc(cnt_e_reg);
                    end
                    if (grid_rdata == KIND_PLAYER)
                    begin
                        cnt_p_next = sat_inc(cnt_p_reg);
                    end
                    grid_we = 1'b1;
                    if (sp_reg < LOAD_W'(CELLS))
                    begin
                        stack_we = 1'b1;
                        sp_next  = sp_reg + LOAD_W'(1);
                    end
                end
            end
            OP_POP:
            begin
                sp_next = sp_dec;
            end
            OP_TAKE:
            begin
                cur_r_next = stack_rdata[STACK_W-1 -: ROW_W];
                cur_c_next = stack_rdata[COL_W-1:0];
            end
            OP_FINISH:
            begin
                load_idx_next = '0;
            end
            default:
            begin
            end
        endcase

        if (cmd.op == OP_SEED || cmd.op == OP_NBR)
        begin
            cand_ok_next = (cand_r_next < ADDR_W'(nr)) && (cand_c_next < nc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= DIM_W'(1);
            cols_reg      <= DIM_W'(1);
            tot_c_reg     <= '0;
            tot_e_reg     <= '0;
            tot_p_reg     <= '0;
            load_idx_reg  <= '0;
            start_idx_reg <= '0;
            start_nc_reg  <= DIM_W'(1);
            cnt_c_reg     <= '0;
            cnt_e_reg     <= '0;
            cnt_p_reg     <= '0;
            sp_reg        <= '0;
            cand_ok_reg   <= 1'b0;
            idx_ok_reg    <= 1'b0;
        end
        else
        begin
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            tot_c_reg     <= tot_c_next;
            tot_e_reg     <= tot_e_next;
            tot_p_reg     <= tot_p_next;
            load_idx_reg  <= load_idx_next;
            start_idx_reg <= start_idx_next;
            start_nc_reg  <= start_nc_next;
            cnt_c_reg     <= cnt_c_next;
            cnt_e_reg     <= cnt_e_next;
            cnt_p_reg     <= cnt_p_next;
            sp_reg        <= sp_next;
            cand_ok_reg   <= cand_ok_next;
            idx_ok_reg    <= idx_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_r_reg <= cand_r_next;
        cand_c_reg <= cand_c_next;
        cur_r_reg  <= cur_r_next;
        cur_c_reg  <= cur_c_next;
        idx_reg    <= idx_next;
    end

    gffrc_ram #(
        .WIDTH (KIND_W),
        .DEPTH (CELLS)
    ) u_grid (
        .clk   (clk),
        .we    (grid_we),
        .waddr (grid_waddr),
        .wdata (grid_wdata),
        .re    (cmd.op == OP_READ),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (grid_rdata)
    );

    gffrc_ram #(
        .WIDTH (STACK_W),
        .DEPTH (CELLS)
    ) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (sp_reg[ADDR_W-1:0]),
        .wdata ({cand_r_reg[ROW_W-1:0], cand_c_reg[COL_W-1:0]}),
        .re    (cmd.op == OP_POP),
        .raddr (sp_dec[ADDR_W-1:0]),
        .rdata (stack_rdata)
    );

    gffrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.op == OP_DIV),
        .dividend  (start_idx_reg),
        .divisor   (start_nc_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign status.div_done = div_done;
    assign status.idx_ok   = idx_ok_reg;
    assign status.sp_zero  = (sp_reg == '0);

    assign result.path_valid = (cnt_c_reg == tot_c_reg) && (cnt_e_reg == tot_e_reg)
                               && (cnt_p_reg == tot_p_reg);
    assign result.reached_collectibles = cnt_c_reg;
    assign result.reached_exits        = cnt_e_reg;
    assign result.reached_players      = cnt_p_reg;

endmodule

`default_nettype wire

// ===== rtl/grid_flood_fill_reach_check_top.sv =====
// Top level of the grid flood-fill reach checker.
//
// Cells are sent as requests in row-major order: a request is taken at a clock
// edge where start is high and busy is low, one cell per cycle while loading.
// The request with last_cell set ends the load and starts the fill; busy then
// stays high until the result has been shown.
// After the edge that takes the last cell, the fill runs the divider launch,
// the wait on the 12-step shift-subtract divider that recovers the start
// position, the seed probe, the final empty-stack check and the result cycle.
// Each reached cell costs a stack pop, a stack read, and for each of its four
// neighbour probes a step, an address multiply, a grid read and, when the
// neighbour lies inside the loaded grid, a mark/push step.
// The result sits on result for exactly one cycle with done high; it cannot be
// held off, so the receiver must take it then. busy drops in the next cycle.
// Settings are written through cfg_valid/cfg_ready (always ready), register
// index in cfg_index, value in cfg_data. The user must write them only while
// busy is low; the block itself does not enforce it.
// Reset returns settings to one row, one column and zero totals, empties the
// load; memory contents are not cleared, there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module grid_flood_fill_reach_check_top import gffrc_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gffrc_item_t          item,
    output logic                 done,
    output gffrc_result_t        result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    gffrc_cmd_t    cmd;
    gffrc_status_t status;

    assign cfg_ready = 1'b1;

    gffrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_cell (item.last_cell),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done)
    );

    gffrc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cell_kind (item.cell_kind),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_last_starts_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_cell) |=> busy)
        else $error("last cell accepted but fill did not start");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last_cell) |=> (!busy && !done))
        else $error("non-final cell left the loader busy");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_grid_flood_fill_reach_check_top.sv =====
// Self-checking testbench for the grid flood-fill reach checker top level.
`timescale 1ns / 1ps

module tb_grid_flood_fill_reach_check_top;
    import gffrc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_WALL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCK = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ODD   = 3'd6;

    localparam int SHAPE_EXACT  = 0;
    localparam int SHAPE_EARLY  = 1;
    localparam int SHAPE_EXCESS = 2;
    localparam int SHAPE_FULL   = 3;

    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 1500000;

    // Predicts the reach counts of each load and checks them against the block.
    class reach_count_board;
        int rows_reg, cols_reg;
        int tot_collect, tot_exit, tot_player;
        logic [KIND_W-1:0] grid [CELLS];
        int fill_stack [CELLS];
        int sp, load_idx, start_r, start_c;
        int reach_collect, reach_exit, reach_player;
        gffrc_result_t want_counts [$];
        int errors;

        function new();
            rows_reg = 1;
            cols_reg = 1;
            tot_collect = 0;
            tot_exit = 0;
            tot_player = 0;
            sp = 0;
            load_idx = 0;
            start_r = 0;
            start_c = 0;
            reach_collect = 0;
            reach_exit = 0;
            reach_player = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
            case (idx)
                REG_ROWS:        rows_reg = data[DIM_W-1:0];
                REG_COLS:        cols_reg = data[DIM_W-1:0];
                REG_TOT_COLLECT: tot_collect = data;
                REG_TOT_EXITS:   tot_exit = data;
                REG_TOT_PLAYERS: tot_player = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return want_counts.size();
        endfunction

        function int bump(int v);
            return (v < CNT_MAX) ? v + 1 : v;
        endfunction

        function void enter(int r, int c, int nr, int nc, int loaded);
            int idx;
            logic [KIND_W-1:0] k;
            if (r >= nr || c >= nc)
                return;
            idx = r * nc + c;
            if (idx >= loaded || idx >= CELLS)
                return;
            k = grid[idx];
            if (k < KIND_FLOOR || k > KIND_PLAYER)
                return;
            if (k == KIND_COLLECT)
                reach_collect = bump(reach_collect);
            if (k == KIND_EXIT)
                reach_exit = bump(reach_exit);
            if (k == KIND_PLAYER)
                reach_player = bump(reach_player);
            grid[idx] = KIND_VISITED;
            if (sp < CELLS)
            begin
                fill_stack[sp] = idx;
                sp++;
            end
        endfunction

        function void take_cell(gffrc_item_t it);
            int nr, nc, area, idx, r, c;
            gffrc_result_t res;
            nr = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
            nc = (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
            area = nr * nc;
            // first cell of a load starts the counts afresh
            if (load_idx == 0)
            begin
                reach_collect = 0;
                reach_exit = 0;
                reach_player = 0;
                start_r = 0;
                start_c = 0;
            end
            if (load_idx < area && load_idx < CELLS)
            begin
                grid[load_idx] = it.cell_kind;
                if (it.cell_kind == KIND_PLAYER)
                begin
                    start_r = load_idx / nc;
                    start_c = load_idx % nc;
                end
                load_idx++;
            end
            if (!it.last_cell)
                return;
            sp = 0;
            if (nr != 0 && nc != 0)
            begin
                enter(start_r, start_c, nr, nc, load_idx);
                while (sp > 0)
                begin
                    sp--;
                    idx = fill_stack[sp];
                    r = idx / nc;
                    c = idx % nc;
                    if (c > 0)
                        enter(r, c - 1, nr, nc, load_idx);
                    enter(r, c + 1, nr, nc, load_idx);
                    if (r > 0)
                        enter(r - 1, c, nr, nc, load_idx);
                    enter(r + 1, c, nr, nc, load_idx);
                end
            end
            res.path_valid = (reach_collect == tot_collect && reach_exit == tot_exit
                              && reach_player == tot_player);
            res.reached_collectibles = CNT_W'(reach_collect);
            res.reached_exits = CNT_W'(reach_exit);
            res.reached_players = CNT_W'(reach_player);
            want_counts.push_back(res);
            load_idx = 0;
        endfunction

        function void check_counts(gffrc_result_t got);
            gffrc_result_t want;
            if (want_counts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                return;
            end
            want = want_counts.pop_front();
            if (got.path_valid !== want.path_valid)
            begin
                errors++;
                $display("%0t: path_valid expected %0d, got %0d",
                         $time, want.path_valid, got.path_valid);
            end
            if (got.reached_collectibles !== want.reached_collectibles)
            begin
                errors++;
                $display("%0t: reached_collectibles expected %0d, got %0d",
                         $time, want.reached_collectibles, got.reached_collectibles);
            end
            if (got.reached_exits !== want.reached_exits)
            begin
                errors++;
                $display("%0t: reached_exits expected %0d, got %0d",
                         $time, want.reached_exits, got.reached_exits);
            end
            if (got.reached_players !== want.reached_players)
            begin
                errors++;
                $display("%0t: reached_players expected %0d, got %0d",
                         $time, want.reached_players, got.reached_players);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    gffrc_item_t          item;
    logic                 done;
    gffrc_result_t        result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    reach_count_board board;
    int  cycles = 0;
    int  n_items = 0;
    int  cur_rows = 1;
    int  cur_cols = 1;
    bit  steady = 1'b0;
    bit  big_done = 1'b0;

    grid_flood_fill_reach_check_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            board.check_counts(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(int open_pct);
        int r;
        if ($urandom_range(0, 99) < open_pct)
            return KIND_FLOOR;
        r = $urandom_range(0, 99);
        if (r < 35)
            return KIND_WALL;
        if (r < 55)
            return KIND_COLLECT;
        if (r < 70)
            return KIND_EXIT;
        if (r < 80)
            return KIND_PLAYER;
        case ($urandom_range(0, 2))
            0:       return KIND_BLOCK;
            1:       return KIND_ODD;
            default: return KIND_VISITED;
        endcase
    endfunction

    task automatic send_cell(input logic [KIND_W-1:0] kind, input logic is_last);
        int gap;
        gffrc_item_t it;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.cell_kind = kind;
        it.last_cell = is_last;
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        board.take_cell(it);
    endtask

    // Hold off until every fill has reported and the block has gone idle.
    task automatic drain_fills();
        start <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        do @(posedge clk); while (busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_setting(input logic [REG_IDX_W-1:0] idx,
                                 input logic [CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, data);
    endtask

    task automatic apply_settings(input int rows, input int cols,
                                  input int tc, input int te, input int tp);
        logic [CNT_W-1:0] d;
        drain_fills();
        cur_rows = rows;
        cur_cols = cols;
        // now and then set the unused upper bits of the size registers
        d = CNT_W'(rows);
        if ($urandom_range(0, 9) == 0)
            d[CNT_W-1:DIM_W] = (CNT_W-DIM_W)'($urandom);
        write_setting(REG_ROWS, d);
        d = CNT_W'(cols);
        if ($urandom_range(0, 9) == 0)
            d[CNT_W-1:DIM_W] = (CNT_W-DIM_W)'($urandom);
        write_setting(REG_COLS, d);
        write_setting(REG_TOT_COLLECT, CNT_W'(tc));
        write_setting(REG_TOT_EXITS, CNT_W'(te));
        write_setting(REG_TOT_PLAYERS, CNT_W'(tp));
        if ($urandom_range(0, 9) == 0)
            write_setting(REG_IDX_W'(REG_TOT_PLAYERS + $urandom_range(1, 3)),
                          CNT_W'($urandom_range(0, 8191)));
        cfg_valid <= 1'b0;
    endtask

    task automatic play_load(input bit fresh, input int rows_sel, input int cols_sel,
                             input int shape, input int open_pct);
        logic [KIND_W-1:0] kinds [$];
        int nr, nc, area, len, stored, tc, te, tp, r;
        if (fresh)
        begin
            nr = rows_sel;
            nc = cols_sel;
        end
        else
        begin
            nr = cur_rows;
            nc = cur_cols;
        end
        nr = (nr > MAX_ROWS) ? MAX_ROWS : nr;
        nc = (nc > MAX_COLS) ? MAX_COLS : nc;
        area = nr * nc;
        if (area > 256 && shape == SHAPE_EXACT)
            shape = SHAPE_EARLY;
        case (shape)
            SHAPE_EARLY:  len = (area == 0) ? $urandom_range(1, 3)
                                : $urandom_range(1, (area < 40) ? area : 40);
            SHAPE_EXCESS: len = area + $urandom_range(1, 4);
            default:      len = (area == 0) ? $urandom_range(1, 3) : area;
        endcase
        for (int i = 0; i < len; i++)
            kinds.push_back(pick_kind(open_pct));
        stored = (len < area) ? len : area;
        // mostly a single player somewhere in the stored part
        if (stored > 0 && $urandom_range(0, 99) < 60)
        begin
            foreach (kinds[i])
                if (kinds[i] == KIND_PLAYER)
                    kinds[i] = KIND_FLOOR;
            kinds[$urandom_range(0, stored - 1)] = KIND_PLAYER;
        end
        if (fresh)
        begin
            tc = 0;
            te = 0;
            tp = 0;
            for (int i = 0; i < stored; i++)
            begin
                if (kinds[i] == KIND_COLLECT)
                    tc++;
                if (kinds[i] == KIND_EXIT)
                    te++;
                if (kinds[i] == KIND_PLAYER)
                    tp++;
            end
            r = $urandom_range(0, 99);
            if (r >= 85)
            begin
                tc = $urandom_range(0, 8191);
                te = $urandom_range(0, 8191);
                tp = $urandom_range(0, 8191);
            end
            else if (r >= 70)
            begin
                case ($urandom_range(0, 2))
                    0:       tc++;
                    1:       te++;
                    default: tp++;
                endcase
            end
            apply_settings(rows_sel, cols_sel, tc, te, tp);
        end
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_cell(kinds[i], i == len - 1);
        n_items += len;
    endtask

    initial
    begin
        int sel, rs, cs, shape;
        board = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single cell under the reset settings
        send_cell(KIND_PLAYER, 1'b1);

        // every kind code on a 3x3 grid, all targets reachable
        apply_settings(3, 3, 1, 1, 1);
        send_cell(KIND_PLAYER, 1'b0);
        send_cell(KIND_FLOOR, 1'b0);
        send_cell(KIND_COLLECT, 1'b0);
        send_cell(KIND_WALL, 1'b0);
        send_cell(KIND_BLOCK, 1'b0);
        send_cell(KIND_EXIT, 1'b0);
        send_cell(KIND_ODD, 1'b0);
        send_cell(KIND_VISITED, 1'b0);
        send_cell(KIND_FLOOR, 1'b1);

        // last cell arrives early; unwritten positions block
        apply_settings(3, 3, 1, 0, 1);
        send_cell(KIND_FLOOR, 1'b0);
        send_cell(KIND_COLLECT, 1'b0);
        send_cell(KIND_PLAYER, 1'b1);

        // excess cell carries the only player, so the fill starts at the origin
        apply_settings(1, 2, 1, 0, 0);
        send_cell(KIND_COLLECT, 1'b0);
        send_cell(KIND_FLOOR, 1'b0);
        send_cell(KIND_PLAYER, 1'b1);

        // zero rows: nothing stored, nothing reached
        apply_settings(0, 5, 0, 0, 1);
        send_cell(KIND_FLOOR, 1'b0);
        send_cell(KIND_PLAYER, 1'b1);

        // oversized row count clamps to the maximum
        apply_settings(127, 1, 0, 1, 1);
        send_cell(KIND_PLAYER, 1'b0);
        send_cell(KIND_EXIT, 1'b1);

        n_items = 0;
        while (n_items < ITEM_TARGET)
        begin
            if (!big_done && n_items >= ITEM_TARGET / 2)
            begin
                play_load(1'b1, MAX_ROWS, 12, SHAPE_FULL, 92);
                big_done = 1'b1;
            end
            else
            begin
                sel = $urandom_range(0, 99);
                shape = SHAPE_EXACT;
                if (sel < 85)
                begin
                    rs = $urandom_range(1, 8);
                    cs = $urandom_range(1, 8);
                end
                else if (sel < 93)
                begin
                    rs = $urandom_range(1, 20);
                    cs = $urandom_range(1, 20);
                end
                else if (sel < 97)
                begin
                    rs = 1;
                    cs = $urandom_range(32, 64);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        rs = cs;
                        cs = 1;
                    end
                end
                else
                begin
                    rs = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(64, 127);
                    case ($urandom_range(0, 2))
                        0:       cs = 0;
                        1:       cs = 1;
                        default: cs = $urandom_range(64, 127);
                    endcase
                    shape = SHAPE_EARLY;
                end
                if (shape == SHAPE_EXACT)
                begin
                    sel = $urandom_range(0, 99);
                    if (sel >= 90)
                        shape = SHAPE_EXCESS;
                    else if (sel >= 78)
                        shape = SHAPE_EARLY;
                end
                play_load($urandom_range(0, 1) == 0, rs, cs, shape,
                          $urandom_range(40, 90));
            end
        end

        drain_fills();
        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
